### sv/bpam_pkg.sv
// Shared types and codes for the breakpoint address match table.
package bpam_pkg;

   localparam int ADDR_W  = 32;
   localparam int KIND_W  = 2;
   localparam int COUNT_W = 5;

   // Request kind codes as they arrive on the bus
   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_REMOVE,
      OP_QUERY
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [ADDR_W-1:0] address;
   } item_type;

   typedef enum logic {
      ST_IDLE,
      ST_RESOLVE
   } state_type;

endpackage

### sv/bpam_front.sv
// Front end: accepts requests, decodes the kind and queues them for the table engine.
module bpam_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [bpam_pkg::ADDR_W-1:0] req_tdata,   // [31:0] address
   input  logic [bpam_pkg::KIND_W-1:0] req_tuser,   // [1:0] kind
   output logic                     item_valid,
   input  logic                     item_ready,
   output bpam_pkg::item_type       item
);
   import bpam_pkg::*;

   localparam int DEPTH = 2;

   item_type   queue_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   item_type   decoded;
   logic       push, pop;

   always_comb begin
      decoded.address = req_tdata;
      case (req_tuser)
         KIND_ADD:    decoded.op = OP_ADD;
         KIND_REMOVE: decoded.op = OP_REMOVE;
         KIND_QUERY:  decoded.op = OP_QUERY;
         default:     decoded.op = OP_QUERY;   // unused code behaves as a query
      endcase
   end

   assign req_tready = (fill_ff != 2'(DEPTH));
   assign item_valid = (fill_ff != 2'd0);
   assign item       = queue_ff[rd_ptr_ff];
   assign push       = req_tvalid & req_tready;
   assign pop        = item_valid & item_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

### sv/bpam_back.sv
// Table engine: parallel compare of stored addresses, then add, remove or query and result.
module bpam_back #(
   parameter int CAPACITY = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   output logic                item_ready,
   input  bpam_pkg::item_type  item,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata    // [0] hit, [1] full_drop, [6:2] entry_count, [7] 0
);
   import bpam_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   state_type             state_ff, state_in;
   item_type              cur_ff, cur_in;
   logic [CAPACITY-1:0]   match_ff, match_in;
   logic [ADDR_W-1:0]     table_ff [CAPACITY];
   logic [CW-1:0]         count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  hit_ff, hit_in;
   logic                  drop_ff, drop_in;
   logic [COUNT_W-1:0]    ecount_ff, ecount_in;

   logic                  tbl_we;
   logic [IW-1:0]         tbl_wa;
   logic [ADDR_W-1:0]     tbl_wd;
   logic                  hit;
   logic [IW-1:0]         slot;
   logic [IW-1:0]         last_idx;
   logic                  out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, ecount_ff, drop_ff, hit_ff};
   assign item_ready = (state_ff == ST_IDLE);
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // Addresses are distinct, so at most one match bit is set: OR the indices
   always_comb begin
      slot = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match_ff[i]) begin
            slot = slot | IW'(i);
         end
      end
   end

   assign hit      = |match_ff;
   assign last_idx = IW'(count_ff - CW'(1));

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      match_in     = match_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      hit_in       = hit_ff;
      drop_in      = drop_ff;
      ecount_in    = ecount_ff;
      tbl_we       = 1'b0;
      tbl_wa       = IW'(count_ff);
      tbl_wd       = cur_ff.address;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               cur_in = item;
               for (int i = 0; i < CAPACITY; i++) begin
                  match_in[i] = (table_ff[i] == item.address) && (CW'(i) < count_ff);
               end
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            if (out_free) begin
               drop_in = 1'b0;
               case (cur_ff.op)
                  OP_ADD: begin
                     if (!hit) begin
                        if (count_ff == CW'(CAPACITY)) begin
                           drop_in = 1'b1;
                        end else begin
                           tbl_we   = 1'b1;
                           tbl_wa   = IW'(count_ff);
                           tbl_wd   = cur_ff.address;
                           count_in = count_ff + CW'(1);
                        end
                     end
                  end
                  OP_REMOVE: begin
                     // Move the last entry into the freed slot
                     if (hit) begin
                        tbl_we   = 1'b1;
                        tbl_wa   = slot;
                        tbl_wd   = table_ff[last_idx];
                        count_in = count_ff - CW'(1);
                     end
                  end
                  default: begin
                  end
               endcase
               hit_in       = hit;
               ecount_in    = COUNT_W'(count_in);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      match_ff  <= match_in;
      hit_ff    <= hit_in;
      drop_ff   <= drop_in;
      ecount_ff <= ecount_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         table_ff[tbl_wa] <= tbl_wd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESOLVE |-> $onehot0(match_ff))
      else $error("duplicate address stored in table");

   a_drop_only_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESOLVE && out_free && drop_in
         |-> cur_ff.op == OP_ADD && !hit && count_ff == CW'(CAPACITY))
      else $error("add dropped while table had room");

endmodule

### sv/breakpoint_address_match_table.sv
// Top level of the breakpoint address match table.
//
//  channel | direction | tdata                                   | tuser
//  req     | in        | [31:0] address                          | [1:0] kind
//  rsp     | out       | [0] hit [1] full_drop [6:2] entry_count | -
//
// Each item passes through the table engine in order: the parallel compare of
// all stored entries, then the resolve and table update; no new item is taken meanwhile.
// A two-entry queue sits between request decode and the engine; the result sits in
// an output register, so the engine moves on once the result is transferred or the
// register is free. Synchronous reset empties the queue and the table count.
module breakpoint_address_match_table #(
   parameter int CAPACITY = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [bpam_pkg::ADDR_W-1:0]  req_tdata,   // [31:0] address
   input  logic [bpam_pkg::KIND_W-1:0]  req_tuser,   // [1:0] kind
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata    // [0] hit, [1] full_drop, [6:2] entry_count
);
   import bpam_pkg::*;

   logic     item_valid;
   logic     item_ready;
   item_type item;

   bpam_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   bpam_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
